/* hw/rtl/dgpf_pkg.sv */
// Shared types and constants of the depth-to-gray pixel filter.
// No dependencies; every other file of the block but dgpf_ram imports this package.
package dgpf_pkg;

  // Default number of rows the column store can hold.
  localparam int unsigned DefMaxColumn = 512;

  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned HeightCfgW = 10;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned GrayW      = 8;
  localparam int unsigned ConfW      = 8;

  localparam logic [HeightCfgW-1:0] HeightReset = HeightCfgW'(132);
  localparam logic [GrayW-1:0]      GrayLimit   = 8'hFF;

  // Register indexes of the configuration channel.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_GAIN_A        = 2'd0,
    CFG_OFFSET_B      = 2'd1,
    CFG_COLUMN_HEIGHT = 2'd2
  } cfg_index_e;

  // One result item; gray sits in the lowest bits so the packed value
  // is the output tdata layout.
  typedef struct packed {
    logic signed [CoordW-1:0] coord_z;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] distance;
    logic        [GrayW-1:0]  gray;
  } pix_res_t;

  localparam int unsigned ResW = $bits(pix_res_t);

  // Position flags of a pixel inside the frame.
  typedef struct packed {
    logic first_col;
    logic top_row;
  } pos_flags_t;

endpackage

/* hw/rtl/dgpf_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old data when the same entry is written in that cycle.
// No dependencies.
module dgpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/dgpf_gray_map.sv */
// Distance to gray mapping: gray = gain * distance + offset in Q15.16,
// clamped to 0..255; a saturated pixel is rejected. Uses dgpf_pkg.
module dgpf_gray_map import dgpf_pkg::*; (
  input  logic signed [CfgDataW-1:0] gain_i,
  input  logic signed [CfgDataW-1:0] offset_i,
  input  logic signed [CoordW-1:0]   distance_i,
  input  logic signed [CoordW-1:0]   coord_y_i,
  input  logic signed [CoordW-1:0]   coord_z_i,
  output pix_res_t                   res_o
);

  localparam int unsigned ProdW = CfgDataW + CoordW;
  localparam int unsigned SumW  = ProdW + 1;

  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  value;
  logic        [GrayW-1:0] gray;
  logic                    saturated;

  assign prod  = gain_i * distance_i;
  assign value = SumW'(prod) + SumW'(offset_i);

  // Integer part is value[SumW-2:16]; anything at or above the limit saturates.
  always_comb begin
    gray      = value[16 +: GrayW];
    saturated = 1'b0;
    if (value[SumW-1]) begin
      gray = '0;
    end else if ((|value[SumW-2:16+GrayW]) || (value[16 +: GrayW] == GrayLimit)) begin
      saturated = 1'b1;
    end
  end

  always_comb begin
    res_o = '0;
    if (!saturated) begin
      res_o.gray     = gray;
      res_o.distance = distance_i;
      res_o.coord_y  = coord_y_i;
      res_o.coord_z  = coord_z_i;
    end
  end

endmodule

/* hw/rtl/dgpf_row_track.sv */
// Row and column position tracker of the pixel stream.
// Advances on every accepted item; uses dgpf_pkg.
module dgpf_row_track import dgpf_pkg::*; #(
  parameter int unsigned MAX_COLUMN = DefMaxColumn
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          frame_start_i,
  input  logic [HeightCfgW-1:0]         column_height_i,
  output logic [$clog2(MAX_COLUMN)-1:0] row_o,
  output pos_flags_t                    flags_o
);

  localparam int unsigned RowW = $clog2(MAX_COLUMN);
  localparam int unsigned HW   = (RowW + 1 > HeightCfgW) ? RowW + 1 : HeightCfgW;

  logic [RowW-1:0] row_q, row_d;
  logic            first_q, first_d;
  logic [RowW-1:0] cur_row;
  logic            cur_first;
  logic [HW-1:0]   height, eff_height, next_row;

  assign cur_row   = frame_start_i ? '0 : row_q;
  assign cur_first = frame_start_i ? 1'b1 : first_q;

  // Clamp the programmed height into 1..MAX_COLUMN.
  always_comb begin
    height     = HW'(column_height_i);
    eff_height = height;
    if (height == '0) begin
      eff_height = HW'(1);
    end else if (height > HW'(MAX_COLUMN)) begin
      eff_height = HW'(MAX_COLUMN);
    end
  end

  assign next_row = HW'(cur_row) + HW'(1);

  always_comb begin
    row_d   = row_q;
    first_d = first_q;
    if (advance_i) begin
      if (next_row >= eff_height) begin
        row_d   = '0;
        first_d = 1'b0;
      end else begin
        row_d   = next_row[RowW-1:0];
        first_d = cur_first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      first_q <= 1'b1;
    end else begin
      row_q   <= row_d;
      first_q <= first_d;
    end
  end

  assign row_o             = cur_row;
  assign flags_o.first_col = cur_first;
  assign flags_o.top_row   = (cur_row == '0);

endmodule

/* hw/rtl/depth_to_gray_pixel_filter.sv */
// Top level of the depth-to-gray pixel filter: config registers, the column
// store, the process stage and the output register. Uses dgpf_pkg, dgpf_ram,
// dgpf_gray_map and dgpf_row_track.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: distance, coord_y,
//            |           |                              |   coord_z, confidence; tuser: frame_start
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: gray, out_distance,
//            |           |                              |   out_coord_y, out_coord_z
//  cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while m_axis does not stall. The accepting
// edge registers the pixel and launches the column store read; when the
// process stage advances, the result is registered in the output register.
// The single read and single write of the column store per pixel set the rate.
// Reset clears counters and config; the column store is not cleared and needs
// no clearing pass if only rows written in an earlier column are read, which
// the user, not the block, must ensure. A stalled m_axis holds the process
// stage; s_axis_tready drops only when the output and process stages are full.
module depth_to_gray_pixel_filter import dgpf_pkg::*; #(
  parameter int unsigned MAX_COLUMN = DefMaxColumn
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] distance, [31:16] coord_y, [47:32] coord_z, [55:48] confidence
  input  logic [55:0]           s_axis_tdata,
  // [0] frame_start
  input  logic                  s_axis_tuser,
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] gray, [23:8] out_distance, [39:24] out_coord_y, [55:40] out_coord_z
  output logic [55:0]           m_axis_tdata,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIndexW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned RowW = $clog2(MAX_COLUMN);

  // Configuration registers
  logic signed [CfgDataW-1:0] gain_q, offset_q;
  logic [HeightCfgW-1:0]      height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      offset_q <= '0;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_GAIN_A:        gain_q   <= cfg_data_i;
        CFG_OFFSET_B:      offset_q <= cfg_data_i;
        CFG_COLUMN_HEIGHT: height_q <= cfg_data_i[HeightCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake of the two stages
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_accept;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Position of the incoming pixel
  logic [RowW-1:0] in_row;
  pos_flags_t      in_flags;

  dgpf_row_track #(
    .MAX_COLUMN(MAX_COLUMN)
  ) u_row_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (in_accept),
    .frame_start_i  (s_axis_tuser),
    .column_height_i(height_q),
    .row_o          (in_row),
    .flags_o        (in_flags)
  );

  // Process stage registers (payload needs no reset)
  logic signed [CoordW-1:0] s1_dist_q, s1_cy_q, s1_cz_q;
  logic [ConfW-1:0]         s1_conf_q;
  logic [RowW-1:0]          s1_row_q;
  pos_flags_t               s1_flags_q;

  // Forwarding of a write to the row being read in the same cycle
  logic     fwd_q;
  pix_res_t fwd_data_q;

  pix_res_t held_q;
  pix_res_t store_rdata;
  pix_res_t mapped;
  pix_res_t above_old;
  pix_res_t diag;
  pix_res_t s1_res;
  pix_res_t out_data_q;
  logic [ResW-1:0] ram_rdata;

  dgpf_ram #(
    .WIDTH(ResW),
    .DEPTH(MAX_COLUMN)
  ) u_column_store (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_row_q),
    .wdata_i(ResW'(s1_res)),
    .re_i   (in_accept),
    .raddr_i(in_row),
    .rdata_o(ram_rdata)
  );

  assign store_rdata = pix_res_t'(ram_rdata);

  dgpf_gray_map u_gray_map (
    .gain_i    (gain_q),
    .offset_i  (offset_q),
    .distance_i(s1_dist_q),
    .coord_y_i (s1_cy_q),
    .coord_z_i (s1_cz_q),
    .res_o     (mapped)
  );

  // Old entry of this row from the previous column; none in the first column.
  always_comb begin
    above_old = '0;
    if (!s1_flags_q.first_col) begin
      above_old = fwd_q ? fwd_data_q : store_rdata;
    end
  end

  // Diagonal neighbour: previous column, row above; zero on the border.
  assign diag   = (s1_flags_q.first_col || s1_flags_q.top_row) ? '0 : held_q;
  assign s1_res = (s1_conf_q != '0) ? diag : mapped;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_dist_q  <= s_axis_tdata[15:0];
      s1_cy_q    <= s_axis_tdata[31:16];
      s1_cz_q    <= s_axis_tdata[47:32];
      s1_conf_q  <= s_axis_tdata[55:48];
      s1_row_q   <= in_row;
      s1_flags_q <= in_flags;
      fwd_data_q <= s1_res;
    end
    if (s1_adv) begin
      out_data_q <= s1_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      held_q      <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        // Hit when the departing item writes the row just read.
        fwd_q      <= s1_adv && (s1_row_q == in_row);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        held_q      <= above_old;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* tb/tb_depth_to_gray_pixel_filter.sv */
// Self-checking testbench of depth_to_gray_pixel_filter: a directed table, then random
// frames over several register settings, checked against an in-bench pixel predictor.
// Depends on dgpf_pkg and the RTL of the block only.
module tb_depth_to_gray_pixel_filter;
  import dgpf_pkg::*;

  localparam int unsigned MaxRows   = DefMaxColumn;
  localparam int unsigned ClkPeriod = 12;
  localparam int unsigned RunLimit  = ClkPeriod * 200000;

  // One pixel as the sender sees it; a typed-in result overrides the predictor.
  typedef struct {
    logic                     fs;
    logic signed [CoordW-1:0] distance;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [ConfW-1:0]         conf;
    bit                       has_exp;
    pix_res_t                 exp_res;
  } pixel_item_t;

  typedef enum {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    pixel_item_t   pix;
    cfg_index_e    reg_idx;
    logic [31:0]   reg_val;
  } dir_row_t;

  // Receiver stall patterns, switched at random intervals.
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [55:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = CFG_GAIN_A;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  depth_to_gray_pixel_filter dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers and filter state, at their reset values.
  // ---------------------------------------------------------------------------
  logic signed [31:0]   gain_q   = '0;
  logic signed [31:0]   offset_q = '0;
  logic [HeightCfgW-1:0] height_q = HeightReset;

  pix_res_t     col_store [MaxRows];
  bit           store_written [MaxRows];
  pix_res_t     held_prev = '0;
  int unsigned  row_cnt   = 0;
  bit           first_col = 1'b1;

  pixel_item_t  pixel_q[$];          // pixels waiting to be driven
  pix_res_t     expected_pix_q[$];   // results owed by the block, oldest first
  int unsigned  pushed_cnt   = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  result_cnt   = 0;
  int unsigned  err_cnt      = 0;

  // Advance the shadow by one accepted pixel and return the result it owes.
  function automatic pix_res_t predict_pixel(pixel_item_t it);
    longint       v;
    int unsigned  row;
    int unsigned  h;
    logic [7:0]   g;
    pix_res_t     res;
    pix_res_t     diag;
    pix_res_t     above;
    if (it.fs) begin
      row_cnt   = 0;
      first_col = 1'b1;
    end
    row = row_cnt % MaxRows;
    v = longint'(gain_q) * longint'(it.distance) + longint'(offset_q);
    if (v < 0) begin
      g = 8'd0;
    end else if ((v >>> 16) >= 255) begin
      g = GrayLimit;
    end else begin
      g = v[23:16];
    end
    // A saturated gray rejects the whole pixel.
    if (g != GrayLimit) begin
      res = '{coord_z: it.cz, coord_y: it.cy, distance: it.distance, gray: g};
    end else begin
      res = '0;
    end
    // Diagonal neighbor exists only off the first column and below row 0.
    diag  = (first_col || row == 0) ? pix_res_t'('0) : held_prev;
    above = first_col ? pix_res_t'('0) : col_store[row];
    if (it.conf != '0) res = diag;
    held_prev          = above;
    col_store[row]     = res;
    store_written[row] = 1'b1;
    // Height 0 acts as 1, anything above the store depth as the depth.
    h = height_q;
    if (h == 0) h = 1;
    if (h > MaxRows) h = MaxRows;
    row_cnt = row + 1;
    if (row_cnt >= h) begin
      row_cnt   = 0;
      first_col = 1'b0;
    end
    return res;
  endfunction

  function automatic pix_res_t res_of(logic [7:0] g, logic [15:0] d, logic [15:0] y,
                                      logic [15:0] z);
    return '{coord_z: z, coord_y: y, distance: d, gray: g};
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("[%0t] result %0d: %s expected %h, got %h", $time, result_cnt, what, want, got);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: drive queued pixels in bursts with random gaps; predict on accept.
  // ---------------------------------------------------------------------------
  pixel_item_t cur_item;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive_pixels
    logic     next_valid;
    pix_res_t pred;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = predict_pixel(cur_item);
        expected_pix_q.insert(expected_pix_q.size(),
                              cur_item.has_exp ? cur_item.exp_res : pred);
        accepted_cnt++;
      end
      // Load a new pixel only once the held one is gone.
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          cur_item = pixel_q.pop_front();
          // Never let a later column read a store row that no column wrote yet:
          // start a new frame instead.
          if (!cur_item.fs && !first_col && !store_written[row_cnt % MaxRows])
            cur_item.fs = 1'b1;
          next_valid = 1'b1;
          s_axis_tdata <= {cur_item.conf, cur_item.cz, cur_item.cy, cur_item.distance};
          s_axis_tuser <= cur_item.fs;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result, stall on a changing pattern.
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = RX_OPEN;
  int unsigned mode_left  = 0;
  int unsigned rx_cycle   = 0;

  always @(posedge clk_i) begin : take_results
    pix_res_t got;
    pix_res_t want;
    logic     next_ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = pix_res_t'(m_axis_tdata);
        if (expected_pix_q.size() == 0) begin
          report_mismatch("result with nothing expected, tdata[15:0]", '0, m_axis_tdata[15:0]);
        end else begin
          want = expected_pix_q.pop_front();
          if (got.gray !== want.gray) report_mismatch("gray", want.gray, got.gray);
          if (got.distance !== want.distance)
            report_mismatch("out_distance", want.distance, got.distance);
          if (got.coord_y !== want.coord_y)
            report_mismatch("out_coord_y", want.coord_y, got.coord_y);
          if (got.coord_z !== want.coord_z)
            report_mismatch("out_coord_z", want.coord_z, got.coord_z);
        end
        result_cnt++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      rx_cycle++;
      case (stall_mode)
        RX_OPEN:   next_ready = 1'b1;
        RX_COIN:   next_ready = 1'($urandom_range(0, 1));
        RX_SPARSE: next_ready = (rx_cycle % 4 == 0);
        default:   next_ready = ($urandom_range(0, 6) != 0);
      endcase
      m_axis_tready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and phase control.
  // ---------------------------------------------------------------------------

  // Hold until every queued pixel is accepted and every result has come,
  // then let the two pipeline stages settle.
  task automatic wait_drain();
    while (accepted_cnt != pushed_cnt || expected_pix_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GAIN_A:        gain_q   = val;
      CFG_OFFSET_B:      offset_q = val;
      CFG_COLUMN_HEIGHT: height_q = val[HeightCfgW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pixel(pixel_item_t it);
    pixel_q.insert(pixel_q.size(), it);
    pushed_cnt++;
  endtask

  dir_row_t table_q[$];

  task automatic add_pix(logic fs, logic [15:0] d, logic [15:0] y, logic [15:0] z,
                         logic [7:0] c, bit chk, pix_res_t e);
    dir_row_t r;
    r.kind = ROW_PIXEL;
    r.pix  = '{fs: fs, distance: d, cy: y, cz: z, conf: c, has_exp: chk, exp_res: e};
    r.reg_idx = CFG_GAIN_A;
    r.reg_val = '0;
    table_q.insert(table_q.size(), r);
  endtask

  task automatic add_reg(cfg_index_e idx, logic [31:0] val);
    dir_row_t r;
    r.kind    = ROW_REG;
    r.pix     = '{default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    table_q.insert(table_q.size(), r);
  endtask

  initial begin : run_test
    pixel_item_t it;
    logic [31:0] gain_v;
    logic [31:0] offset_v;
    logic [9:0]  height_v;
    int unsigned ph;
    int unsigned k;

    // Directed table. Reset values first: zero gain and offset keep every
    // valid pixel at gray 0, and nothing has marked a frame start yet.
    add_pix(0, 16'h8000, 16'h7FFF, 16'h8000, 8'h00, 1, res_of(0, 16'h8000, 16'h7FFF, 16'h8000));
    add_pix(0, 16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 1, res_of(0, 16'h7FFF, 16'h8000, 16'h7FFF));
    add_pix(0, 16'd100, 16'd5, 16'd6, 8'hFF, 1, '0);      // invalid on the first column
    add_pix(1, 16'd7, 16'd8, 16'd9, 8'h00, 1, res_of(0, 16'd7, 16'd8, 16'd9));
    // Height zero acts as one row: every pixel sits in row 0.
    add_reg(CFG_COLUMN_HEIGHT, 32'd0);
    add_pix(1, 16'd11, 16'd12, 16'd13, 8'h00, 1, res_of(0, 16'd11, 16'd12, 16'd13));
    add_pix(0, 16'd20, 16'd21, 16'd22, 8'h80, 1, '0);     // invalid in row 0
    // Unit gain, two-row columns: saturation, negative gray and diagonal copies.
    add_reg(CFG_GAIN_A, 32'h0001_0000);
    add_reg(CFG_OFFSET_B, 32'h0000_0000);
    add_reg(CFG_COLUMN_HEIGHT, 32'd2);
    add_pix(1, 16'd10, 16'd1, 16'd2, 8'h00, 1, res_of(10, 16'd10, 16'd1, 16'd2));
    add_pix(0, 16'd300, 16'd3, 16'd4, 8'h00, 1, '0);     // rejected
    add_pix(0, 16'hFFFB, 16'd5, 16'd6, 8'h00, 1, res_of(0, 16'hFFFB, 16'd5, 16'd6));
    add_pix(0, 16'd254, 16'd7, 16'd8, 8'h01, 0, '0);      // copy from the diagonal
    add_pix(0, 16'd254, 16'd9, 16'd10, 8'h00, 1, res_of(254, 16'd254, 16'd9, 16'd10));
    add_pix(0, 16'd0, 16'd0, 16'd0, 8'h01, 0, '0);
    // Extreme gain and offset in both pairings.
    add_reg(CFG_OFFSET_B, 32'h7FFF_FFFF);
    add_reg(CFG_GAIN_A, 32'h8000_0000);
    add_pix(0, 16'h8000, 16'd1, 16'd1, 8'h00, 1, '0);
    add_pix(0, 16'h7FFF, 16'd2, 16'd2, 8'h00, 1, res_of(0, 16'h7FFF, 16'd2, 16'd2));
    add_reg(CFG_GAIN_A, 32'h7FFF_FFFF);
    add_reg(CFG_OFFSET_B, 32'h8000_0000);
    add_pix(0, 16'h7FFF, 16'd3, 16'd3, 8'h00, 1, '0);
    add_pix(0, 16'd0, 16'd4, 16'd4, 8'h00, 1, res_of(0, 16'd0, 16'd4, 16'd4));
    // Lower the height mid-column: the pixel after the change closes the column.
    add_reg(CFG_COLUMN_HEIGHT, 32'd4);
    add_pix(1, 16'd1, 16'd1, 16'd1, 8'h00, 0, '0);
    add_pix(0, 16'd2, 16'd2, 16'd2, 8'h00, 0, '0);
    add_pix(0, 16'd3, 16'd3, 16'd3, 8'h00, 0, '0);
    add_reg(CFG_COLUMN_HEIGHT, 32'd2);
    add_pix(0, 16'd40, 16'd1, 16'd1, 8'h00, 0, '0);
    add_pix(0, 16'd41, 16'd2, 16'd2, 8'h10, 1, '0);      // row 0 of the new column
    add_pix(0, 16'd42, 16'd3, 16'd3, 8'h02, 0, '0);

    // Hold reset once, then release it.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the table; drain before every register write.
    foreach (table_q[i]) begin
      if (table_q[i].kind == ROW_REG) begin
        wait_drain();
        write_reg(table_q[i].reg_idx, table_q[i].reg_val);
      end else begin
        push_pixel(table_q[i].pix);
      end
    end

    // Random phases: new settings, then frames of random pixels.
    for (ph = 0; ph < 8; ph++) begin
      wait_drain();
      case ($urandom_range(0, 5))
        0:       gain_v = 32'h7FFF_FFFF;
        1:       gain_v = 32'h8000_0000;
        2:       gain_v = $urandom;
        default: begin
          gain_v = $urandom_range(0, 32'h0000_1000);
          if ($urandom_range(0, 1)) gain_v = -gain_v;
        end
      endcase
      case ($urandom_range(0, 5))
        0:       offset_v = 32'h7FFF_FFFF;
        1:       offset_v = 32'h8000_0000;
        2:       offset_v = $urandom;
        default: offset_v = $urandom_range(0, 300 << 16) - (40 << 16);
      endcase
      // Mostly short columns; the largest settings only now and then.
      if (ph == 0) begin
        height_v = 10'h3FF;
      end else if (ph == 1) begin
        height_v = 10'd0;
      end else begin
        case ($urandom_range(0, 7))
          0:       height_v = 10'd512;
          1:       height_v = 10'd1;
          default: height_v = 10'($urandom_range(2, 9));
        endcase
      end
      write_reg(CFG_GAIN_A, gain_v);
      write_reg(CFG_OFFSET_B, offset_v);
      write_reg(CFG_COLUMN_HEIGHT, {22'd0, height_v});

      for (k = 0; k < 56; k++) begin
        it.fs = (k == 0 && $urandom_range(0, 3) != 0) || ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 3))
          0:       it.distance = 16'($urandom);
          1:       it.distance = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          default: it.distance = 16'(int'($urandom_range(0, 1000)) - 200);
        endcase
        it.cy      = 16'($urandom);
        it.cz      = 16'($urandom);
        it.conf    = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        it.has_exp = 1'b0;
        it.exp_res = '0;
        push_pixel(it);
      end
    end

    // Hold until everything has come out, then idle a little longer.
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run well after the slowest correct one would have ended.
  initial begin : watchdog
    #(RunLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
